FILE: design/rksd_pkg.sv
// ----------------------------------------------------------------------------
// rksd_pkg
// Shared widths, limits, register indexes and types for the rotary knob
// setting decoder.
// ----------------------------------------------------------------------------
package rksd_pkg;

	// Raw scan and knob widths
	localparam int SCAN_W    = 8;
	localparam int KNOB_W    = 2;
	localparam int KNOBS_W   = 3 * KNOB_W;

	// Every setting register is held on four bits
	localparam int SET_W     = 4;
	localparam int WAVE_OUT_W = 2;
	localparam int BPOS_W    = 3;

	// Setting limits
	localparam int VOL_TOP    = 12;
	localparam int VOL_BOTTOM = 0;
	localparam int OCT_TOP    = 8;
	localparam int OCT_BOTTOM = 2;

	// Reset values of the settings
	localparam logic [SET_W-1:0]   VOL_RESET    = SET_W'(8);
	localparam logic [SET_W-1:0]   OCT_RESET    = SET_W'(4);
	localparam logic [SET_W-1:0]   OFFSET_RESET = 4'hC;
	localparam logic [KNOBS_W-1:0] KNOBS_RESET  = '1;

	// Defaults of the top level parameters
	localparam int WAVE_COUNT_DEF = 4;
	localparam int WAVE_RESET_DEF = 0;

	// Quadrature codes of one knob
	localparam logic [KNOB_W-1:0] Q_00 = 2'b00;
	localparam logic [KNOB_W-1:0] Q_01 = 2'b01;
	localparam logic [KNOB_W-1:0] Q_10 = 2'b10;
	localparam logic [KNOB_W-1:0] Q_11 = 2'b11;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = BPOS_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECEIVER_MODE  = 2'd0,
		REG_BOARD_POSITION = 2'd1
	} cfg_reg_t;

	// Outcome of one knob for one scan
	typedef struct packed {
		logic             changed;
		logic [SET_W-1:0] next;
	} knob_upd_t;

endpackage

FILE: design/rksd_ifs.sv
// ----------------------------------------------------------------------------
// rksd interfaces
// Valid/ready channels of the decoder: scan input, result output and
// configuration writes.
// ----------------------------------------------------------------------------

// Scan request channel
interface rksd_scan_if;
	logic                        valid;
	logic                        ready;
	logic [rksd_pkg::SCAN_W-1:0] knob_bits;

	modport source (output valid, output knob_bits, input ready);
	modport sink (input valid, input knob_bits, output ready);
endinterface

// Result request channel
interface rksd_result_if;
	logic                             valid;
	logic                             ready;
	logic [rksd_pkg::SET_W-1:0]       volume_level;
	logic [rksd_pkg::SET_W-1:0]       octave_value;
	logic [rksd_pkg::WAVE_OUT_W-1:0]  wave_select;
	logic signed [rksd_pkg::SET_W-1:0] octave_offset;
	logic                             octave_event;

	modport source (output valid, output volume_level, output octave_value,
		output wave_select, output octave_offset, output octave_event, input ready);
	modport sink (input valid, input volume_level, input octave_value,
		input wave_select, input octave_offset, input octave_event, output ready);
endinterface

// Configuration write channel
interface rksd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rksd_pkg::CFG_IDX_W-1:0]  index;
	logic [rksd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/rksd_knob_step.sv
// ----------------------------------------------------------------------------
// rksd_knob_step
// Quadrature decode of one knob against its previous bits, with a
// saturating step of the setting it drives.
// ----------------------------------------------------------------------------
module rksd_knob_step #(
	parameter int TOP    = 1,
	parameter int BOTTOM = 0
) (
	input  logic [rksd_pkg::KNOB_W-1:0] cur,
	input  logic [rksd_pkg::KNOB_W-1:0] prev,
	input  logic [rksd_pkg::SET_W-1:0]  val,
	output rksd_pkg::knob_upd_t         upd
);
	import rksd_pkg::*;

	logic up;
	logic down;

	// Decode direction: 11->10 and 00->01 count up, 01->00 and 10->11 down
	assign up   = (prev == Q_11 && cur == Q_10) || (prev == Q_00 && cur == Q_01);
	assign down = (prev == Q_01 && cur == Q_00) || (prev == Q_10 && cur == Q_11);

	// Step the setting, drop a count past a limit
	always_comb begin
		upd.changed = (cur != prev);
		upd.next    = val;
		if (up && val < SET_W'(TOP)) begin
			upd.next = val + SET_W'(1);
		end else if (down && val > SET_W'(BOTTOM)) begin
			upd.next = val - SET_W'(1);
		end
	end

endmodule

FILE: design/rksd_core.sv
// ----------------------------------------------------------------------------
// rksd_core
// Scan input register, setting state, decode logic and result register.
// ----------------------------------------------------------------------------
module rksd_core #(
	parameter int WAVE_COUNT = rksd_pkg::WAVE_COUNT_DEF,
	parameter int WAVE_RESET = rksd_pkg::WAVE_RESET_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        receiver_mode,
	input  logic [rksd_pkg::BPOS_W-1:0] board_position,
	rksd_scan_if.sink                   scan,
	rksd_result_if.source               result
);
	import rksd_pkg::*;

	localparam int WRAP_DEPTH = 2 ** SET_W;

	logic               valid_s1;
	logic [KNOBS_W-1:0] knobs_s1;
	logic               valid_s2;
	logic               load_s2;
	logic               adv_s2;

	logic [KNOBS_W-1:0] prev_q;
	logic [SET_W-1:0]   vol_q;
	logic [SET_W-1:0]   oct_q;
	logic [SET_W-1:0]   wave_q;
	logic [SET_W-1:0]   offset_q;

	knob_upd_t vol_upd;
	knob_upd_t oct_upd;
	knob_upd_t wave_upd;

	logic [SET_W-1:0] vol_next;
	logic [SET_W-1:0] oct_next;
	logic [SET_W-1:0] wave_next;
	logic [SET_W-1:0] offset_next;
	logic [SET_W-1:0] wave_wrap [WRAP_DEPTH];

	logic [SET_W-1:0]      vol_s2;
	logic [SET_W-1:0]      oct_s2;
	logic [WAVE_OUT_W-1:0] wave_s2;
	logic [SET_W-1:0]      offset_s2;
	logic                  event_s2;

	// Handshake: result stage frees when empty or taken
	assign adv_s2     = !valid_s2 || result.ready;
	assign load_s2    = valid_s1 && adv_s2;
	assign scan.ready = !valid_s1 || adv_s2;

	// Scan input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.valid && scan.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			knobs_s1 <= scan.knob_bits[KNOBS_W-1:0];
		end
	end

	// Per-knob decode
	rksd_knob_step #(.TOP(VOL_TOP), .BOTTOM(VOL_BOTTOM)) u_vol (
		.cur  (knobs_s1[1:0]),
		.prev (prev_q[1:0]),
		.val  (vol_q),
		.upd  (vol_upd)
	);

	rksd_knob_step #(.TOP(OCT_TOP), .BOTTOM(OCT_BOTTOM)) u_oct (
		.cur  (knobs_s1[3:2]),
		.prev (prev_q[3:2]),
		.val  (oct_q),
		.upd  (oct_upd)
	);

	rksd_knob_step #(.TOP(WAVE_COUNT - 1), .BOTTOM(0)) u_wave (
		.cur  (knobs_s1[5:4]),
		.prev (prev_q[5:4]),
		.val  (wave_q),
		.upd  (wave_upd)
	);

	// Wrap table for the waveform index
	for (genvar i = 0; i < WRAP_DEPTH; i++) begin : g_wrap
		assign wave_wrap[i] = SET_W'(i % WAVE_COUNT);
	end

	// Next settings
	always_comb begin
		vol_next    = vol_upd.changed ? vol_upd.next : vol_q;
		oct_next    = oct_upd.changed ? oct_upd.next : oct_q;
		wave_next   = wave_upd.changed ? wave_wrap[wave_upd.next] : wave_q;
		offset_next = oct_upd.changed ? (SET_W'(board_position) - oct_upd.next) : offset_q;
		if (!receiver_mode) begin
			vol_next = '0;
		end
	end

	// Setting state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= KNOBS_RESET;
			vol_q    <= VOL_RESET;
			oct_q    <= OCT_RESET;
			wave_q   <= SET_W'(WAVE_RESET);
			offset_q <= OFFSET_RESET;
		end else if (load_s2) begin
			prev_q   <= knobs_s1;
			vol_q    <= vol_next;
			oct_q    <= oct_next;
			wave_q   <= wave_next;
			offset_q <= offset_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			vol_s2    <= vol_next;
			oct_s2    <= oct_next;
			wave_s2   <= wave_next[WAVE_OUT_W-1:0];
			offset_s2 <= offset_next;
			event_s2  <= oct_upd.changed;
		end
	end

	assign result.valid         = valid_s2;
	assign result.volume_level  = vol_s2;
	assign result.octave_value  = oct_s2;
	assign result.wave_select   = wave_s2;
	assign result.octave_offset = offset_s2;
	assign result.octave_event  = event_s2;

`ifndef SYNTHESIS
	a_oct_range: assert property (@(posedge clk) disable iff (!arst_n)
		oct_q >= SET_W'(OCT_BOTTOM) && oct_q <= SET_W'(OCT_TOP))
		else $error("octave setting left its limits");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		vol_q <= SET_W'(VOL_TOP))
		else $error("volume setting above its top");

	a_wave_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(wave_q) < WAVE_COUNT || wave_q == SET_W'(WAVE_RESET))
		else $error("waveform index out of range");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> valid_s2)
		else $error("decoded scan did not reach the result register");
`endif

endmodule

FILE: design/rotary_knob_setting_decoder.sv
// ----------------------------------------------------------------------------
// rotary_knob_setting_decoder
// Decodes three quadrature knobs (volume, octave, waveform) from raw scans
// of the knob rows into saturating settings, one result per scan.
// ----------------------------------------------------------------------------
// Usage:
//   scan   : one request per scan of the knob rows, knob_bits[5:0] used.
//   result : one request per scan with volume, octave, waveform index,
//            octave offset and the octave change flag after that scan.
//   cfg    : register writes, index 0 receiver_mode, 1 board_position;
//            always ready, other indexes are ignored. Write only while
//            no scan is in flight.
// A scan is held in the scan register and then in the result register,
// where its result can be taken. A scan is taken every cycle while the
// receiver takes the results; the rate is set by the single state update
// per scan.
// When the receiver stalls, the result register holds and one more scan
// is taken into the scan register; after that scan.ready drops.
// Reset clears both stages, sets volume 8, octave 4, waveform WAVE_RESET,
// offset -4, previous knob bits all ones and both registers to zero.
// ----------------------------------------------------------------------------
module rotary_knob_setting_decoder #(
	parameter int WAVE_COUNT = rksd_pkg::WAVE_COUNT_DEF,
	parameter int WAVE_RESET = rksd_pkg::WAVE_RESET_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rksd_scan_if.sink     scan,
	rksd_result_if.source result,
	rksd_cfg_if.sink      cfg
);
	import rksd_pkg::*;

	logic              receiver_mode_q;
	logic [BPOS_W-1:0] board_position_q;

	assign cfg.ready = 1'b1;

	// Decode register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiver_mode_q  <= 1'b0;
			board_position_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_RECEIVER_MODE: begin
					receiver_mode_q <= cfg.data[0];
				end
				REG_BOARD_POSITION: begin
					board_position_q <= cfg.data[BPOS_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rksd_core #(
		.WAVE_COUNT (WAVE_COUNT),
		.WAVE_RESET (WAVE_RESET)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.receiver_mode  (receiver_mode_q),
		.board_position (board_position_q),
		.scan           (scan),
		.result         (result)
	);

endmodule
